// ----- rtl/pps_pkg.sv -----
`timescale 1ns / 1ps
package pps_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int SUM_W = 40;
   localparam int TIME_W = 32;
   // finish time t+1 kept one bit wider than the clock
   localparam int SPAN_W = TIME_W + 1;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_TICK    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic        we;
      logic [3:0]  slot;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] prio;
   } load_cmd_type;

   // running best candidate handed from cell to cell
   typedef struct packed {
      logic        found;
      logic [15:0] prio;
      logic [15:0] arrival;
      logic [15:0] orig;
      logic [15:0] rem;
   } token_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [SPAN_W-1:0] v);
      logic [SUM_W:0] s;
      begin
         s = {1'b0, acc} + (SUM_W+1)'(v);
         sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
      end
   endfunction

   function automatic logic [15:0] sat16(input logic [SPAN_W-1:0] v);
      begin
         sat16 = (v > SPAN_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
      end
   endfunction

endpackage

// ----- rtl/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Channel   Ports                      Handshake
// --------  -------------------------  -------------------------------------
// request   req_mode .. req_priority_req  taken when start high, busy low
// response  rsp_ran .. rsp_total_turnaround  valid one cycle with rsp_strobe
//
// Load, restart and unused-mode items answer in the cycle after acceptance and
// leave busy low. For a tick item, the best-candidate token walks the cell
// chain one slot per cycle, then completion arithmetic runs through states
// S_CALC1, S_CALC2 and S_CALC3 before the strobe. Reset is synchronous and
// empties every slot and clears the clock and totals. The receiver cannot
// stall; each response is on the ports for exactly one cycle.
module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic [3:0]   req_slot,
   input  logic [15:0]  req_arrival,
   input  logic [15:0]  req_burst,
   input  logic [15:0]  req_priority_req,
   output logic         rsp_strobe,
   output logic         rsp_ran,
   output logic [3:0]   rsp_served_slot,
   output logic         rsp_finished,
   output logic [15:0]  rsp_wait_time,
   output logic [15:0]  rsp_turnaround,
   output logic [31:0]  rsp_time_now,
   output logic [39:0]  rsp_total_wait,
   output logic [39:0]  rsp_total_turnaround
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_CALC1 = 3'd2;
   localparam logic [2:0] S_CALC2 = 3'd3;
   localparam logic [2:0] S_CALC3 = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     cnt_ff, cnt_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [SUM_W-1:0]  wsum_ff, wsum_in;
   logic [SUM_W-1:0]  tsum_ff, tsum_in;

   // completion pipeline
   logic              found_ff, found_in;
   logic [IW-1:0]     win_ff, win_in;
   logic              fin_ff, fin_in;
   logic [SPAN_W-1:0] tat_ff, tat_in;
   logic [15:0]       orig_ff, orig_in;
   logic [SPAN_W-1:0] wt_ff, wt_in;

   logic              strobe_ff, strobe_in;
   logic              ran_ff, ran_in;
   logic [3:0]        slot_ff, slot_in;
   logic              finr_ff, finr_in;
   logic [15:0]       wtr_ff, wtr_in;
   logic [15:0]       tatr_ff, tatr_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SUM_W-1:0]  wtot_ff, wtot_in;
   logic [SUM_W-1:0]  ttot_ff, ttot_in;

   logic              accept;
   load_cmd_type      load_cmd;
   logic              serve_en;

   token_type         tok [0:SLOTS];
   logic [IW-1:0]     idx [0:SLOTS];

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // slot writes land at the accept edge; out-of-range slots are dropped
   assign load_cmd.we      = accept && (req_mode == MODE_LOAD)
                             && ({28'b0, req_slot} < 32'(SLOTS));
   assign load_cmd.slot    = req_slot;
   assign load_cmd.arrival = req_arrival;
   assign load_cmd.burst   = req_burst;
   assign load_cmd.prio    = req_priority_req;

   // the winner gives up one unit as the chain result is consumed
   assign serve_en = (state_ff == S_CALC1) && tok[SLOTS].found;

   // cell chain: empty token enters at the head
   assign tok[0] = '0;
   assign idx[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      pps_cell #(
         .SLOTS    (SLOTS),
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_cmd  (load_cmd),
         .serve_en  (serve_en),
         .serve_idx (idx[SLOTS]),
         .t_now     (tick_ff),
         .tok_in    (tok[g]),
         .idx_in    (idx[g]),
         .tok_out   (tok[g+1]),
         .idx_out   (idx[g+1])
      );
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      tick_in   = tick_ff;
      wsum_in   = wsum_ff;
      tsum_in   = tsum_ff;
      found_in  = found_ff;
      win_in    = win_ff;
      fin_in    = fin_ff;
      tat_in    = tat_ff;
      orig_in   = orig_ff;
      wt_in     = wt_ff;
      strobe_in = 1'b0;
      ran_in    = ran_ff;
      slot_in   = slot_ff;
      finr_in   = finr_ff;
      wtr_in    = wtr_ff;
      tatr_in   = tatr_ff;
      time_in   = time_ff;
      wtot_in   = wtot_ff;
      ttot_in   = ttot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_TICK) begin
                  state_in = S_SCAN;
                  cnt_in   = '0;
               end else begin
                  // non-tick items answer right away
                  strobe_in = 1'b1;
                  ran_in    = 1'b0;
                  slot_in   = 4'd0;
                  finr_in   = 1'b0;
                  wtr_in    = 16'd0;
                  tatr_in   = 16'd0;
                  time_in   = tick_ff;
                  wtot_in   = wsum_ff;
                  ttot_in   = tsum_ff;
                  if (req_mode == MODE_RESTART) begin
                     tick_in = '0;
                     wsum_in = '0;
                     tsum_in = '0;
                     time_in = '0;
                     wtot_in = '0;
                     ttot_in = '0;
                  end
               end
            end
         end
         S_SCAN: begin
            // token walks every cell of the chain before it reaches the chain tail
            if (cnt_ff == IW'(SLOTS - 1)) begin
               state_in = S_CALC1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CALC1: begin
            found_in = tok[SLOTS].found;
            win_in   = idx[SLOTS];
            fin_in   = tok[SLOTS].found && (tok[SLOTS].rem == 16'd1);
            // finish time computed one bit wider so it never wraps
            tat_in   = ({1'b0, tick_ff} + SPAN_W'(1)) - SPAN_W'(tok[SLOTS].arrival);
            orig_in  = tok[SLOTS].orig;
            tick_in  = tick_ff + 1'b1;
            state_in = S_CALC2;
         end
         S_CALC2: begin
            // negative wait after a restart or reload clamps to zero
            wt_in    = (tat_ff >= SPAN_W'(orig_ff)) ? tat_ff - SPAN_W'(orig_ff) : '0;
            state_in = S_CALC3;
         end
         S_CALC3: begin
            strobe_in = 1'b1;
            ran_in    = found_ff;
            slot_in   = found_ff ? 4'(win_ff) : 4'd0;
            finr_in   = fin_ff;
            wtr_in    = 16'd0;
            tatr_in   = 16'd0;
            if (fin_ff) begin
               wtr_in  = sat16(wt_ff);
               tatr_in = sat16(tat_ff);
               wsum_in = sat_add(wsum_ff, wt_ff);
               tsum_in = sat_add(tsum_ff, tat_ff);
            end
            time_in  = tick_ff;
            wtot_in  = wsum_in;
            ttot_in  = tsum_in;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tick_ff   <= '0;
         wsum_ff   <= '0;
         tsum_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         wsum_ff   <= wsum_in;
         tsum_ff   <= tsum_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      win_ff   <= win_in;
      fin_ff   <= fin_in;
      tat_ff   <= tat_in;
      orig_ff  <= orig_in;
      wt_ff    <= wt_in;
      ran_ff   <= ran_in;
      slot_ff  <= slot_in;
      finr_ff  <= finr_in;
      wtr_ff   <= wtr_in;
      tatr_ff  <= tatr_in;
      time_ff  <= time_in;
      wtot_ff  <= wtot_in;
      ttot_ff  <= ttot_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_ran              = ran_ff;
   assign rsp_served_slot      = slot_ff;
   assign rsp_finished         = finr_ff;
   assign rsp_wait_time        = wtr_ff;
   assign rsp_turnaround       = tatr_ff;
   assign rsp_time_now         = time_ff;
   assign rsp_total_wait       = wtot_ff;
   assign rsp_total_turnaround = ttot_ff;

endmodule

// ----- rtl/pps_cell.sv -----
`timescale 1ns / 1ps
module pps_cell import pps_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int CELL_IDX = 0,
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  load_cmd_type        load_cmd,
   input  logic                serve_en,
   input  logic [IW-1:0]       serve_idx,
   input  logic [TIME_W-1:0]   t_now,
   input  token_type           tok_in,
   input  logic [IW-1:0]       idx_in,
   output token_type           tok_out,
   output logic [IW-1:0]       idx_out
);

   logic [15:0] arrival_ff, arrival_in;
   logic [15:0] orig_ff, orig_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] prio_ff, prio_in;
   token_type   tok_ff, tok_in_nx;
   logic [IW-1:0] idx_ff, idx_in_nx;
   logic        hit_load, hit_serve, eligible, take;

   assign hit_load  = load_cmd.we && ({28'b0, load_cmd.slot} == 32'(CELL_IDX));
   assign hit_serve = serve_en && (32'(serve_idx) == 32'(CELL_IDX));

   always_comb begin
      arrival_in = arrival_ff;
      orig_in    = orig_ff;
      rem_in     = rem_ff;
      prio_in    = prio_ff;
      if (hit_load) begin
         arrival_in = load_cmd.arrival;
         orig_in    = load_cmd.burst;
         rem_in     = load_cmd.burst;
         prio_in    = load_cmd.prio;
      end else if (hit_serve) begin
         rem_in = rem_ff - 16'd1;
      end
   end

   // strict less-than keeps the lower slot on equal priority
   assign eligible = (rem_ff != 16'd0) && ({16'b0, arrival_ff} <= t_now);
   assign take = eligible && (!tok_in.found || (prio_ff < tok_in.prio));

   always_comb begin
      tok_in_nx = tok_in;
      idx_in_nx = idx_in;
      if (take) begin
         tok_in_nx.found   = 1'b1;
         tok_in_nx.prio    = prio_ff;
         tok_in_nx.arrival = arrival_ff;
         tok_in_nx.orig    = orig_ff;
         tok_in_nx.rem     = rem_ff;
         idx_in_nx         = IW'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      orig_ff    <= orig_in;
      prio_ff    <= prio_in;
      tok_ff     <= tok_in_nx;
      idx_ff     <= idx_in_nx;
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule
